// ----- src/utt_pkg.sv -----
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package utt_pkg;

	// Depth of the job queue between front end and back end.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// Code point width (up to U+10FFFF).
	localparam int unsigned CP_W = 21;

	// Surrogate prefixes on the upper six bits of a code unit.
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// Offset added to a joined surrogate pair.
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	// What the back end does with one job.
	typedef enum logic [1:0] {
		JOB_ENCODE   = 2'd0,
		JOB_BARE_END = 2'd1,
		JOB_ERROR    = 2'd2
	} job_kind_t;

	// One job handed from the front end to the back end.
	typedef struct packed {
		job_kind_t         kind;
		logic [CP_W-1:0]   cp;
		logic              last;
	} job_t;

	// Queue status seen by the front end and the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- src/utf16_to_utf8_transcoder_core.sv -----
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and
// back end. Depends on utt_pkg, utt_front, utt_queue and utt_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_stall  | in_byte, in_last
//   output   | out_valid / out_stall| utf8_byte, has_byte, out_last,
//            |                      | bad_surrogate
//   config   | cfg_wr_en            | cfg_wr_data (big_endian)
//
// The front end takes one source byte per cycle while the four-entry job
// queue has room; each job is one code point, end marker or error marker.
// The back end sends one result byte per cycle while the output is not
// stalled; a two-byte unit that gives three UTF-8 bytes makes the back
// end the limit on sustained throughput. A popped job waits in the
// current-job register and its bytes pass through the output register.
// Reset clears the stream state, the queue and the output valid flag.
// A stall on the output side backs up the queue and then stalls the input.
module utf16_to_utf8_transcoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] utf8_byte,
	output logic       has_byte,
	output logic       out_last,
	output logic       bad_surrogate
);
	import utt_pkg::*;

	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head_job;
	q_status_t q_status;

	// Byte assembly and surrogate pairing.
	utt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.in_last     (in_last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_status    (q_status),
		.push        (push),
		.push_job    (push_job)
	);

	// Job queue decoupling the two sides.
	utt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	// UTF-8 serialization.
	utt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.utf8_byte     (utf8_byte),
		.has_byte      (has_byte),
		.out_last      (out_last),
		.bad_surrogate (bad_surrogate)
	);

endmodule

// ----- src/utt_front.sv -----
// Front end: takes source bytes, builds code units, pairs surrogates and
// pushes one encode, end or error job into the queue.
// Depends on utt_pkg.
module utt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  utt_pkg::q_status_t q_status,
	output logic          push,
	output utt_pkg::job_t push_job
);
	import utt_pkg::*;

	logic        big_endian_q;
	logic [7:0]  first_byte_q;
	logic        byte_phase_q;
	logic [9:0]  high_hold_q;
	logic        high_pending_q;
	logic        drop_q;

	logic [7:0]  first_byte_d;
	logic        byte_phase_d;
	logic [9:0]  high_hold_d;
	logic        high_pending_d;
	logic        drop_d;

	logic        accept;
	logic [15:0] unit;
	logic        is_high;
	logic        is_low;
	logic [CP_W-1:0] pair_cp;

	// A byte transfers whenever the queue has room for a job.
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// Assemble the code unit from the held byte and the arriving byte.
	assign unit    = big_endian_q ? {first_byte_q, in_byte} : {in_byte, first_byte_q};
	assign is_high = (unit[15:10] == HIGH_SURR_TAG);
	assign is_low  = (unit[15:10] == LOW_SURR_TAG);
	assign pair_cp = {1'b0, high_hold_q, unit[9:0]} + SUPP_BASE;

	// Classify the byte and decide the next stream state and the job.
	always_comb begin
		first_byte_d   = first_byte_q;
		byte_phase_d   = byte_phase_q;
		high_hold_d    = high_hold_q;
		high_pending_d = high_pending_q;
		drop_d         = drop_q;
		push           = 1'b0;
		push_job.kind  = JOB_ENCODE;
		push_job.cp    = {5'd0, unit};
		push_job.last  = in_last;
		if (accept) begin
			if (drop_q) begin
				if (in_last) begin
					drop_d = 1'b0;
				end
			end else if (!byte_phase_q) begin
				if (in_last) begin
					// An odd trailing byte is dropped; flush a held high surrogate.
					push          = 1'b1;
					push_job.last = 1'b1;
					if (high_pending_q) begin
						push_job.kind = JOB_ENCODE;
						push_job.cp   = {5'd0, HIGH_SURR_TAG, high_hold_q};
					end else begin
						push_job.kind = JOB_BARE_END;
					end
					high_pending_d = 1'b0;
					high_hold_d    = '0;
					first_byte_d   = '0;
				end else begin
					first_byte_d = in_byte;
					byte_phase_d = 1'b1;
				end
			end else begin
				byte_phase_d = 1'b0;
				if (high_pending_q) begin
					push = 1'b1;
					if (is_low) begin
						push_job.kind  = JOB_ENCODE;
						push_job.cp    = pair_cp;
						high_pending_d = 1'b0;
					end else begin
						// Broken pair ends the conversion.
						push_job.kind  = JOB_ERROR;
						push_job.last  = 1'b1;
						high_pending_d = 1'b0;
						drop_d         = !in_last;
					end
				end else if (is_high) begin
					if (in_last) begin
						// A trailing high surrogate is encoded on its own.
						push = 1'b1;
					end else begin
						high_hold_d    = unit[9:0];
						high_pending_d = 1'b1;
					end
				end else if (is_low) begin
					// A lone low surrogate ends the conversion.
					push          = 1'b1;
					push_job.kind = JOB_ERROR;
					push_job.last = 1'b1;
					drop_d        = !in_last;
				end else begin
					push = 1'b1;
				end
				if (in_last || (push_job.kind == JOB_ERROR && push)) begin
					high_hold_d  = '0;
					first_byte_d = '0;
				end
			end
		end
	end

	// Stream state and the endianness register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q   <= 1'b0;
			first_byte_q   <= '0;
			byte_phase_q   <= 1'b0;
			high_hold_q    <= '0;
			high_pending_q <= 1'b0;
			drop_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				big_endian_q <= cfg_wr_data;
			end
			first_byte_q   <= first_byte_d;
			byte_phase_q   <= byte_phase_d;
			high_hold_q    <= high_hold_d;
			high_pending_q <= high_pending_d;
			drop_q         <= drop_d;
		end
	end

	// While dropping after an error, no unit or surrogate is in progress.
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (!byte_phase_q && !high_pending_q))
		else $error("drop mode with unit or surrogate in progress");

	// A job is only pushed when the queue has room.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("job pushed into a full queue");

	// An error job always ends the stream it belongs to.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_job.kind == JOB_ERROR) |-> push_job.last)
		else $error("error job without end mark");

endmodule

// ----- src/utt_queue.sv -----
// Short job queue between front end and back end, held in flip-flops.
// Depends on utt_pkg.
module utt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utt_pkg::job_t      push_job,
	input  logic               pop,
	output utt_pkg::job_t      head_job,
	output utt_pkg::q_status_t status
);
	import utt_pkg::*;

	job_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign head_job     = slots_q[rd_ptr_q];

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The fill count never passes the depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	// No pop from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from an empty queue");

endmodule

// ----- src/utt_back.sv -----
// Back end: takes jobs from the queue and sends their UTF-8 bytes out one
// per cycle through an output register while the output is not stalled.
// Depends on utt_pkg.
module utt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  utt_pkg::q_status_t q_status,
	input  utt_pkg::job_t      head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         utf8_byte,
	output logic               has_byte,
	output logic               out_last,
	output logic               bad_surrogate
);
	import utt_pkg::*;

	job_t        cur_q;
	logic        cur_valid_q;
	logic [1:0]  idx_q;

	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        has_q;
	logic        last_q;
	logic        bad_q;

	logic        load_out;
	logic [1:0]  last_idx;
	logic [1:0]  remain;
	logic [7:0]  lead_byte;
	logic [5:0]  cont_bits;
	logic [7:0]  cur_byte;
	logic        finishing;

	// Byte count of the current job, less one.
	always_comb begin
		if (cur_q.kind != JOB_ENCODE) begin
			last_idx = 2'd0;
		end else if (cur_q.cp < CP_W'(32'h80)) begin
			last_idx = 2'd0;
		end else if (cur_q.cp < CP_W'(32'h800)) begin
			last_idx = 2'd1;
		end else if (cur_q.cp < CP_W'(32'h10000)) begin
			last_idx = 2'd2;
		end else begin
			last_idx = 2'd3;
		end
	end

	// Lead byte and continuation bytes of the current code point.
	assign remain = last_idx - idx_q;
	always_comb begin
		case (last_idx)
			2'd0:    lead_byte = cur_q.cp[7:0];
			2'd1:    lead_byte = {3'b110, cur_q.cp[10:6]};
			2'd2:    lead_byte = {4'b1110, cur_q.cp[15:12]};
			default: lead_byte = {5'b11110, cur_q.cp[20:18]};
		endcase
		case (remain)
			2'd0:    cont_bits = cur_q.cp[5:0];
			2'd1:    cont_bits = cur_q.cp[11:6];
			default: cont_bits = cur_q.cp[17:12];
		endcase
		if (cur_q.kind != JOB_ENCODE) begin
			cur_byte = 8'h00;
		end else if (idx_q == 2'd0) begin
			cur_byte = lead_byte;
		end else begin
			cur_byte = {2'b10, cont_bits};
		end
	end

	// Advance when the output register is free or being transferred.
	assign load_out  = !out_valid_q || !out_stall;
	assign finishing = cur_valid_q && load_out && (idx_q == last_idx);
	assign pop       = !q_status.empty && (!cur_valid_q || finishing);

	// Current job and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (finishing) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (cur_valid_q && load_out) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			byte_q <= cur_byte;
			has_q  <= (cur_q.kind == JOB_ENCODE);
			last_q <= cur_q.last && (idx_q == last_idx);
			bad_q  <= (cur_q.kind == JOB_ERROR);
		end
	end

	assign out_valid     = out_valid_q;
	assign utf8_byte     = byte_q;
	assign has_byte      = has_q;
	assign out_last      = last_q;
	assign bad_surrogate = bad_q;

	// The byte index never runs past the length of the code point.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (idx_q <= last_idx))
		else $error("byte index past end of code point");

	// An error result is a bare marker that ends the stream.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> (last_q && !has_q))
		else $error("malformed error result");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for utf16_to_utf8_transcoder_core.
// Drives UTF-16 byte streams in both byte orders, predicts the UTF-8 results and
// checks every output transfer. Needs only the transcoder RTL and its package.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CLK_HALF      = 10;
	localparam int unsigned RESET_CYCLES  = 9;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned PHASE_ITEMS   = 48;
	localparam int unsigned PRINT_LIMIT   = 50;

	// Upper six bits of a surrogate code unit.
	localparam bit [5:0] HIGH_TAG = 6'b110110;
	localparam bit [5:0] LOW_TAG  = 6'b110111;
	localparam bit [20:0] SUPP_OFFSET = 21'h10000;

	// Kinds of code unit the random streams are built from.
	typedef enum int {
		UNIT_ASCII,
		UNIT_TWO_BYTE,
		UNIT_BMP,
		UNIT_PAIR,
		UNIT_NOISE
	} unit_kind_t;

	// How a random stream is closed.
	typedef enum int {
		END_PLAIN,
		END_ODD_BYTE,
		END_TRAIL_HIGH,
		END_LONE_LOW,
		END_BROKEN_PAIR
	} stream_end_t;

	// Receiver stall patterns.
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       last;
		logic       bad;
	} utf8_result_t;

	// Tracks the transcoder's stream state and the UTF-8 results still owed.
	class transcode_checker;
		bit           big_endian;
		bit [7:0]     first_hold;
		bit           byte_pending;
		bit [9:0]     high_hold;
		bit           high_held;
		bit           dropping;
		utf8_result_t awaited_utf8[$];
		int unsigned  fail_count;

		function void clear_stream();
			first_hold   = '0;
			byte_pending = 1'b0;
			high_hold    = '0;
			high_held    = 1'b0;
			dropping     = 1'b0;
		endfunction

		function void push_result(bit [7:0] data, bit has_data, bit last, bit bad);
			utf8_result_t r;
			r.data     = data;
			r.has_data = has_data;
			r.last     = last;
			r.bad      = bad;
			awaited_utf8.push_back(r);
		endfunction

		// Splits one code point into its UTF-8 bytes; only the final one may carry last.
		function void push_code_point(bit [20:0] cp, bit last);
			if (cp < 21'h80) begin
				push_result(cp[7:0], 1'b1, last, 1'b0);
			end else if (cp < 21'h800) begin
				push_result({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b1, last, 1'b0);
			end else if (cp < 21'h10000) begin
				push_result({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b1, last, 1'b0);
			end else begin
				push_result({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b1, last, 1'b0);
			end
		endfunction

		// An unpaired surrogate gives one error result; the rest of the stream is dropped.
		function void flag_error(bit last);
			push_result(8'h00, 1'b0, 1'b1, 1'b1);
			clear_stream();
			dropping = !last;
		endfunction

		function void note_source_byte(bit [7:0] data, bit last);
			bit [15:0] code_unit;
			if (dropping) begin
				if (last)
					clear_stream();
				return;
			end
			// First byte of a unit, or an odd trailing byte that closes the stream.
			if (!byte_pending) begin
				if (last) begin
					if (high_held)
						push_code_point({5'd0, HIGH_TAG, high_hold}, 1'b1);
					else
						push_result(8'h00, 1'b0, 1'b1, 1'b0);
					clear_stream();
				end else begin
					first_hold   = data;
					byte_pending = 1'b1;
				end
				return;
			end
			// Second byte: the byte order is taken at this point.
			byte_pending = 1'b0;
			code_unit = big_endian ? {first_hold, data} : {data, first_hold};
			if (high_held) begin
				if (code_unit[15:10] == LOW_TAG) begin
					high_held = 1'b0;
					push_code_point({1'b0, high_hold, code_unit[9:0]} + SUPP_OFFSET, last);
					if (last)
						clear_stream();
				end else begin
					flag_error(last);
				end
				return;
			end
			if (code_unit[15:10] == HIGH_TAG) begin
				if (last) begin
					// A high surrogate ending the stream goes out on its own.
					push_code_point({5'd0, code_unit}, 1'b1);
					clear_stream();
				end else begin
					high_hold = code_unit[9:0];
					high_held = 1'b1;
				end
			end else if (code_unit[15:10] == LOW_TAG) begin
				flag_error(last);
			end else begin
				push_code_point({5'd0, code_unit}, last);
				if (last)
					clear_stream();
			end
		endfunction

		task report_mismatch(string msg);
			if (fail_count < PRINT_LIMIT)
				$display("%0t ns: mismatch: %s", $time, msg);
			fail_count++;
		endtask

		task check_utf8_result(logic [7:0] data, logic has_data, logic last, logic bad);
			utf8_result_t want;
			if (awaited_utf8.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte=%02h has=%b last=%b bad=%b",
					data, has_data, last, bad));
				return;
			end
			want = awaited_utf8.pop_front();
			if (data !== want.data)
				report_mismatch($sformatf("utf8_byte %02h, expected %02h", data, want.data));
			if (has_data !== want.has_data)
				report_mismatch($sformatf("has_byte %b, expected %b", has_data, want.has_data));
			if (last !== want.last)
				report_mismatch($sformatf("out_last %b, expected %b", last, want.last));
			if (bad !== want.bad)
				report_mismatch($sformatf("bad_surrogate %b, expected %b", bad, want.bad));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] utf8_byte;
	logic       has_byte;
	logic       out_last;
	logic       bad_surrogate;

	transcode_checker sb;
	bit [7:0]         stream_q[$];
	int unsigned      sent_count = 0;
	int unsigned      burst_left = 0;
	int unsigned      cycle_count = 0;
	int unsigned      stall_left = 0;
	stall_mode_t      stall_mode = STALL_NONE;

	utf16_to_utf8_transcoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.utf8_byte     (utf8_byte),
		.has_byte      (has_byte),
		.out_last      (out_last),
		.bad_surrogate (bad_surrogate)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver stall: a random pattern, switched after a random run length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(40, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
			STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
			default:        out_stall <= 1'b0;
		endcase
	end

	// Outputs are steady from the falling edge to the edge that takes the transfer.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_utf8_result(utf8_byte, has_byte, out_last, bad_surrogate);
	end

	// Presents one byte and returns at the edge that takes the transfer.
	task send_item(bit [7:0] data, bit last);
		in_valid <= 1'b1;
		in_byte  <= data;
		in_last  <= last;
		do
			@(negedge clk);
		while (in_stall !== 1'b0);
		sb.note_source_byte(data, last);
		sent_count++;
		@(posedge clk);
	endtask

	// Sender bursts of random length with random gaps; some bursts run on without a gap.
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Waits until every result has come, then for a further settling time.
	task settle();
		in_valid <= 1'b0;
		while (sb.awaited_utf8.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_order(bit be);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= be;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.big_endian = be;
	endtask

	function automatic void add_unit(bit [15:0] code_unit, bit be);
		if (be) begin
			stream_q.push_back(code_unit[15:8]);
			stream_q.push_back(code_unit[7:0]);
		end else begin
			stream_q.push_back(code_unit[7:0]);
			stream_q.push_back(code_unit[15:8]);
		end
	endfunction

	function automatic void add_random_unit(bit be);
		unit_kind_t kind;
		bit [15:0]  code_unit;
		int unsigned w;
		w = $urandom_range(0, 99);
		kind = (w < 30) ? UNIT_ASCII : (w < 45) ? UNIT_TWO_BYTE :
			(w < 65) ? UNIT_BMP : (w < 88) ? UNIT_PAIR : UNIT_NOISE;
		case (kind)
			UNIT_ASCII:    code_unit = 16'($urandom_range(16'h0000, 16'h007F));
			UNIT_TWO_BYTE: code_unit = 16'($urandom_range(16'h0080, 16'h07FF));
			UNIT_BMP: begin
				code_unit = 16'($urandom_range(16'h0800, 16'hFFFF));
				// Move surrogate values up into the private use area.
				if (code_unit[15:11] == 5'b11011)
					code_unit[15:11] = 5'b11100;
			end
			UNIT_PAIR: begin
				add_unit({HIGH_TAG, 10'($urandom)}, be);
				code_unit = {LOW_TAG, 10'($urandom)};
			end
			default:       code_unit = 16'($urandom);
		endcase
		add_unit(code_unit, be);
	endfunction

	task automatic send_queue(bit close);
		int unsigned i;
		for (i = 0; i < stream_q.size(); i++) begin
			pace();
			send_item(stream_q[i], close && (i == stream_q.size() - 1));
		end
		stream_q.delete();
	endtask

	// One random stream: mostly well-formed text, sometimes closed by a special case.
	task automatic send_stream(bit be);
		int unsigned n_units;
		int unsigned i;
		int unsigned w;
		bit [15:0]   code_unit;
		stream_end_t ending;
		n_units = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
		w = $urandom_range(0, 99);
		ending = (w < 60) ? END_PLAIN : (w < 72) ? END_ODD_BYTE : (w < 80) ? END_TRAIL_HIGH :
			(w < 90) ? END_LONE_LOW : END_BROKEN_PAIR;
		for (i = 0; i < n_units; i++)
			add_random_unit(be);
		case (ending)
			END_PLAIN: begin
				if (stream_q.size() == 0)
					add_random_unit(be);
			end
			END_ODD_BYTE: stream_q.push_back(8'($urandom));
			END_TRAIL_HIGH: begin
				add_unit({HIGH_TAG, 10'($urandom)}, be);
				if ($urandom_range(0, 2) == 0)
					stream_q.push_back(8'($urandom));
			end
			default: begin
				if (ending == END_BROKEN_PAIR) begin
					add_unit({HIGH_TAG, 10'($urandom)}, be);
					code_unit = 16'($urandom);
					// Turn an accidental low surrogate into a high one so the pair breaks.
					if (code_unit[15:10] == LOW_TAG)
						code_unit[10] = 1'b0;
					add_unit(code_unit, be);
				end else begin
					add_unit({LOW_TAG, 10'($urandom)}, be);
				end
				// Trailing units after the error are dropped by the block.
				repeat ($urandom_range(0, 3)) add_random_unit(be);
				if ($urandom_range(0, 3) == 0)
					stream_q.push_back(8'($urandom));
			end
		endcase
		send_queue(1'b1);
	endtask

	initial begin
		int unsigned phase;
		int unsigned phase_start;
		bit          order;

		sb = new;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_byte     <= '0;
		in_last     <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, little-endian: one-, two- and three-byte code points at the extremes.
		add_unit(16'h0000, 1'b0);
		add_unit(16'h07FF, 1'b0);
		add_unit(16'hFFFF, 1'b0);
		send_queue(1'b1);
		// Lowest supplementary code point.
		add_unit(16'hD800, 1'b0);
		add_unit(16'hDC00, 1'b0);
		send_queue(1'b1);
		// Lone low surrogate, then a dropped byte that ends the stream.
		add_unit(16'hDFFF, 1'b0);
		stream_q.push_back(8'hFF);
		send_queue(1'b1);
		// Odd byte alone: bare end marker.
		stream_q.push_back(8'h00);
		send_queue(1'b1);
		// Broken pair whose second unit ends the stream.
		add_unit(16'hDBFF, 1'b0);
		add_unit(16'h0041, 1'b0);
		send_queue(1'b1);
		// High surrogate as the last unit.
		add_unit(16'hDBFF, 1'b0);
		send_queue(1'b1);
		// High surrogate followed by an odd trailing byte.
		add_unit(16'hD800, 1'b0);
		stream_q.push_back(8'hA5);
		send_queue(1'b1);
		// Byte order switched between the two bytes of a unit, then the highest code point.
		stream_q.push_back(8'hDB);
		send_queue(1'b0);
		settle();
		set_order(1'b1);
		stream_q.push_back(8'hFF);
		add_unit(16'hDFFF, 1'b1);
		send_queue(1'b1);

		// Random phases, each under its own byte order.
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			order = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
			set_order(order);
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_ITEMS)
				send_stream(order);
		end

		settle();
		if (sb.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
